FILE: rtl/base64url_stream_decoder_macros.svh
// Assertion macros for the base64url stream decoder.
`ifndef BASE64URL_STREAM_DECODER_MACROS_SVH
`define BASE64URL_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define B64U_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define B64U_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define B64U_ASSERT_SAME(label, clk, rst, ante, cons)
`define B64U_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/b64u_pkg.sv
// Types, status codes and the character-to-digit map of the base64url decoder.
package b64u_pkg;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_LEN   = 3'd1,
    STATUS_BAD_CHAR  = 3'd2,
    STATUS_AFTER_PAD = 3'd3,
    STATUS_LEFTOVER  = 3'd4
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } digit_t;

  localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='

  function automatic digit_t char_to_digit(input logic [7:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin        // A-Z
      d.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin  // a-z
      d.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin  // 0-9
      d.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2d) begin               // '-'
      d.value = 6'd62;
    end else if (c == 8'h5f) begin               // '_'
      d.value = 6'd63;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/base64url_stream_decoder.sv
// Base64url stream decoder: one character per beat in, at most one byte per beat out.
//
// Input channel: char_code / is_last beats under in_valid / in_ready. Each
// character is mapped to a 6-bit digit and packed MSB first into bytes.
// Output channel: out_byte / byte_valid / string_done / decode_status under
// out_valid / out_ready. A non-final character gives a beat only when it
// completes a byte and no error is held; the character flagged is_last
// always gives one closing beat with the status (ok, bad length, bad char,
// data after padding, nonzero leftover bits). A byte riding on the closing
// beat is kept only when the status is ok; on error the receiver drops the
// bytes already delivered for that string.
// Each result is registered on the edge that accepts its input character.
// Throughput: one character per cycle while the receiver keeps up, set by the single output register;
// the decode and residue update sit between the state and that register.
// in_ready is high while the output register is empty or being drained, so
// a stalled receiver holds the result and stops input while it is held.
// Reset (rst, synchronous, active high) clears the residue, bit count,
// padding flag, length count, error and the output valid flag. After the
// closing beat the decoder returns to the same state for the next string.
`include "base64url_stream_decoder_macros.svh"

module base64url_stream_decoder
  import b64u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_done,
  output logic [2:0] decode_status
);

  // String state
  logic [5:0] bit_residue;
  logic [2:0] residue_count;
  logic       padding_seen;
  logic [1:0] length_mod_four;
  status_t    error_code;

  logic [5:0] bit_residue_next;
  logic [2:0] residue_count_next;
  logic       padding_seen_next;
  status_t    error_code_next;
  logic [1:0] len;

  // Decode path
  digit_t     digit;
  logic [11:0] acc;
  logic [3:0]  cnt;
  logic [3:0]  cnt_left;
  logic [11:0] acc_shift;
  logic [11:0] keep_mask;
  logic        have;
  logic [7:0]  dec_byte;
  status_t     status;
  logic        emit;

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign digit     = char_to_digit(char_code);
  assign acc       = {bit_residue, digit.value};
  assign cnt       = {1'b0, residue_count} + 4'd6;
  assign cnt_left  = cnt - 4'd8;
  assign acc_shift = acc >> cnt_left;
  assign keep_mask = (12'd1 << cnt_left) - 12'd1;
  assign len       = length_mod_four + 2'd1;

  always_comb begin
    bit_residue_next   = bit_residue;
    residue_count_next = residue_count;
    padding_seen_next  = padding_seen;
    error_code_next    = error_code;
    have               = 1'b0;
    dec_byte           = 8'd0;
    if (char_code == CHAR_PAD) begin
      padding_seen_next = 1'b1;
    end else if (padding_seen) begin
      if (error_code == STATUS_OK) error_code_next = STATUS_AFTER_PAD;
    end else if (!digit.ok) begin
      if (error_code == STATUS_OK) error_code_next = STATUS_BAD_CHAR;
    end else if (error_code == STATUS_OK) begin
      if (cnt >= 4'd8) begin
        // byte completes; the remaining low bits stay in the residue
        have               = 1'b1;
        dec_byte           = acc_shift[7:0];
        bit_residue_next   = acc[5:0] & keep_mask[5:0];
        residue_count_next = cnt_left[2:0];
      end else begin
        bit_residue_next   = acc[5:0];
        residue_count_next = cnt[2:0];
      end
    end
  end

  // Closing status, by precedence
  always_comb begin
    priority if (len == 2'd1) begin
      status = STATUS_BAD_LEN;
    end else if (error_code_next != STATUS_OK) begin
      status = error_code_next;
    end else if (residue_count_next != 3'd0 && bit_residue_next != 6'd0) begin
      status = STATUS_LEFTOVER;
    end else begin
      status = STATUS_OK;
    end
  end

  assign emit = is_last || (have && error_code_next == STATUS_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_residue     <= 6'd0;
      residue_count   <= 3'd0;
      padding_seen    <= 1'b0;
      length_mod_four <= 2'd0;
      error_code      <= STATUS_OK;
    end else if (accept) begin
      if (is_last) begin
        bit_residue     <= 6'd0;
        residue_count   <= 3'd0;
        padding_seen    <= 1'b0;
        length_mod_four <= 2'd0;
        error_code      <= STATUS_OK;
      end else begin
        bit_residue     <= bit_residue_next;
        residue_count   <= residue_count_next;
        padding_seen    <= padding_seen_next;
        length_mod_four <= len;
        error_code      <= error_code_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (is_last && !(have && status == STATUS_OK)) begin
        out_byte      <= 8'd0;
        byte_valid    <= 1'b0;
        decode_status <= status;
      end else begin
        out_byte      <= dec_byte;
        byte_valid    <= 1'b1;
        decode_status <= STATUS_OK;
      end
      string_done <= is_last;
    end
  end

  // A delivered byte always comes with an ok status.
  `B64U_ASSERT_SAME(a_byte_ok, clk, rst, out_valid && byte_valid,
                    decode_status == STATUS_OK)
  // A result that does not close the string always carries a byte.
  `B64U_ASSERT_SAME(a_mid_has_byte, clk, rst, out_valid && !string_done, byte_valid)
  // The closing character returns the string state to its reset values.
  `B64U_ASSERT_NEXT(a_close_clears, clk, rst, accept && is_last,
                    residue_count == 3'd0 && length_mod_four == 2'd0 &&
                    error_code == STATUS_OK && !padding_seen)

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the base64url stream decoder.
`timescale 1ns / 1ps

module tb
  import b64u_pkg::*;
();

  // One output beat as the decoder should produce it.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       done;
    status_t    status;
  } decoded_beat_t;

  // Directed stimulus row: one character, plus a hand-written expectation
  // where the answer is obvious (typed = 1). Other rows go through the predictor.
  typedef struct packed {
    logic [7:0]    ch;
    logic          last;
    logic          typed;
    decoded_beat_t want;
  } char_row_t;

  typedef enum int {
    KIND_CLEAN,
    KIND_LEFTOVER,
    KIND_BAD_LEN,
    KIND_BAD_CHAR,
    KIND_EARLY_PAD,
    KIND_NOISE
  } string_kind_t;

  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_AFTER   = 700;  // no idling past this many items
  localparam int STALL_AT     = 250;  // long receiver hold-off
  localparam int DRAIN_AT     = 450;  // sender waits for all results
  localparam int LONG_HOLD    = 60;
  localparam int WATCHDOG     = 1000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [2:0] decode_status;

  base64url_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .string_done  (string_done),
    .decode_status(decode_status)
  );

  always #1 clk = ~clk;

  // Predictor state: mirrors the decoder's residue, count, pad flag,
  // length mod 4 and sticky error.
  logic [5:0] res_bits;
  int         res_cnt;
  logic       pad_seen;
  logic [1:0] len_mod;
  status_t    held_err;

  decoded_beat_t decoded_q[$];   // beats the decoder still owes us
  int            fail_count;
  int            items_sent;
  int            idle_cycles;
  bit            idle_on;
  bit            hold_long;
  logic          typed_row;      // current input beat carries its own expectation
  decoded_beat_t typed_beat;

  char_row_t dir_rows [23];

  initial begin
    dir_rows = '{
      // single char: length 1 mod 4
      '{"A",    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_BAD_LEN}},
      // all-ones digits, four leftover bits set
      '{"_",    1'b0, 1'b0, '0},
      '{"_",    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_LEFTOVER}},
      // "AQ==" decodes to one byte, closed by padding
      '{"A",    1'b0, 1'b0, '0},
      '{"Q",    1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, STATUS_OK}},
      '{CHAR_PAD, 1'b0, 1'b0, '0},
      '{CHAR_PAD, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_OK}},
      // full quad, last byte rides on the closing beat
      '{"-",    1'b0, 1'b0, '0},
      '{"_",    1'b0, 1'b1, '{8'hfb, 1'b1, 1'b0, STATUS_OK}},
      '{"A",    1'b0, 1'b1, '{8'hf0, 1'b1, 1'b0, STATUS_OK}},
      '{"9",    1'b1, 1'b1, '{8'h3d, 1'b1, 1'b1, STATUS_OK}},
      // invalid char, error sticks and swallows later bytes
      '{"A",    1'b0, 1'b0, '0},
      '{8'hff,  1'b0, 1'b0, '0},
      '{"A",    1'b0, 1'b0, '0},
      '{"A",    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_BAD_CHAR}},
      // digit after padding
      '{"Q",    1'b0, 1'b0, '0},
      '{CHAR_PAD, 1'b0, 1'b0, '0},
      '{"A",    1'b0, 1'b0, '0},
      '{CHAR_PAD, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_AFTER_PAD}},
      // invalid char after padding still counts as data after padding
      '{"A",    1'b0, 1'b0, '0},
      '{CHAR_PAD, 1'b0, 1'b0, '0},
      '{"*",    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_AFTER_PAD}},
      // bad length wins over bad char
      '{8'h00,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_BAD_LEN}}
    };
  end

  function automatic int digit_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "-") return 62;
    if (c == "_") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] char_of(input int d);
    if (d < 26) return 8'(int'("A") + d);
    if (d < 52) return 8'(int'("a") + d - 26);
    if (d < 62) return 8'(int'("0") + d - 52);
    if (d == 62) return "-";
    return "_";
  endfunction

  function automatic void clear_decoder_state();
    res_bits = '0;
    res_cnt  = 0;
    pad_seen = 1'b0;
    len_mod  = '0;
    held_err = STATUS_OK;
  endfunction

  // Advance the predicted decoder by one character; returns 1 when a beat
  // is due and fills it in.
  function automatic logic decode_char(input logic [7:0] c, input logic last,
                                       output decoded_beat_t beat);
    int          d;
    int          cnt;
    logic [11:0] acc;
    logic        have;
    logic [7:0]  byt;
    logic [1:0]  len;
    status_t     st;
    len  = len_mod + 2'd1;
    have = 1'b0;
    byt  = '0;
    beat = '0;
    if (c == CHAR_PAD) begin
      pad_seen = 1'b1;
    end else if (pad_seen) begin
      if (held_err == STATUS_OK) held_err = STATUS_AFTER_PAD;
    end else begin
      d = digit_of(c);
      if (d < 0) begin
        if (held_err == STATUS_OK) held_err = STATUS_BAD_CHAR;
      end else if (held_err == STATUS_OK) begin
        acc = {res_bits, 6'(d)};
        cnt = res_cnt + 6;
        if (cnt >= 8) begin
          cnt  = cnt - 8;
          byt  = 8'(acc >> cnt);
          have = 1'b1;
        end
        res_bits = 6'(acc & ((12'd1 << cnt) - 12'd1));
        res_cnt  = cnt;
      end
    end

    if (!last) begin
      len_mod = len;
      if (have && held_err == STATUS_OK) begin
        beat = '{byt, 1'b1, 1'b0, STATUS_OK};
        return 1'b1;
      end
      return 1'b0;
    end

    // closing beat: length beats error beats leftover bits
    if (len == 2'd1) st = STATUS_BAD_LEN;
    else if (held_err != STATUS_OK) st = held_err;
    else if (res_cnt != 0 && res_bits != 0) st = STATUS_LEFTOVER;
    else st = STATUS_OK;
    if (have && st == STATUS_OK) beat = '{byt, 1'b1, 1'b1, STATUS_OK};
    else beat = '{8'h00, 1'b0, 1'b1, st};
    clear_decoder_state();
    return 1'b1;
  endfunction

  // Present one character and hold it until the decoder takes it. Called
  // and returns at a falling edge; in_valid gets one assignment per edge.
  task automatic send_char(input logic [7:0] c, input logic last,
                           input logic typed, input decoded_beat_t want);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    char_code  <= c;
    is_last    <= last;
    typed_row  = typed;
    typed_beat = want;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Build one string: mostly well-formed with random content, the rest
  // broken in one specific way or plain noise.
  task automatic send_string();
    logic [7:0]   s[$];
    int           n;
    int           d;
    int           r;
    string_kind_t kind;
    r = $urandom_range(0, 15);
    if (r <= 8) kind = KIND_CLEAN;
    else if (r == 9) kind = KIND_LEFTOVER;
    else if (r == 10) kind = KIND_BAD_LEN;
    else if (r <= 12) kind = KIND_BAD_CHAR;
    else if (r == 13) kind = KIND_EARLY_PAD;
    else kind = KIND_NOISE;

    n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 10);
    if (kind == KIND_BAD_LEN) n = n - (n % 4) + 1;
    else if (n % 4 == 1) n++;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, 63);
      // well-formed tail: the bits that don't fill a byte must be zero
      if (i == n - 1 && kind != KIND_LEFTOVER) begin
        if (n % 4 == 2) d = d & 'h30;
        else if (n % 4 == 3) d = d & 'h3c;
      end
      s.insert(s.size(), char_of(d));
    end
    if ($urandom_range(0, 1) == 1) begin
      while (s.size() % 4 != 0) s.insert(s.size(), CHAR_PAD);
    end

    case (kind)
      KIND_BAD_CHAR:  s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      KIND_EARLY_PAD: s.insert($urandom_range(0, s.size() - 1), CHAR_PAD);
      KIND_NOISE: begin
        s = {};
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) s.insert(s.size(), 8'($urandom_range(0, 255)));
      end
      default: ;
    endcase

    foreach (s[i]) send_char(s[i], i == s.size() - 1, 1'b0, '0);
  endtask

  // Sender: reset, directed rows, then random strings with the two
  // pressure phases, then drain and report.
  initial begin
    bit stall_done;
    bit drain_done;
    rst        = 1'b1;
    in_valid   = 1'b0;
    char_code  = '0;
    is_last    = 1'b0;
    typed_row  = 1'b0;
    typed_beat = '0;
    idle_on    = 1'b1;
    hold_long  = 1'b0;
    items_sent = 0;
    fail_count = 0;
    stall_done = 1'b0;
    drain_done = 1'b0;
    clear_decoder_state();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

    while (items_sent < RANDOM_ITEMS) begin
      if (!stall_done && items_sent >= STALL_AT) begin
        // receiver freezes while we keep pushing: output fills, input stalls
        hold_long  = 1'b1;
        stall_done = 1'b1;
      end
      if (!drain_done && items_sent >= DRAIN_AT) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (decoded_q.size() != 0) @(negedge clk);
        drain_done = 1'b1;
      end
      if (items_sent >= CALM_AFTER) idle_on = 1'b0;
      send_string();
    end

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);  // catch any stray beat after the last one
    if (fail_count == 0 && decoded_q.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // Receiver: random back-pressure bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: sample both handshakes on the rising edge. Output beats are
  // checked against the oldest expectation; accepted input beats feed the
  // predictor. Also runs the no-progress watchdog.
  always @(posedge clk) begin
    decoded_beat_t beat;
    decoded_beat_t want;
    logic          due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: byte=%h valid=%b done=%b status=%0d",
                     out_byte, byte_valid, string_done, decode_status);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || byte_valid !== want.has_byte ||
              string_done !== want.done || decode_status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp byte=%h v=%b d=%b st=%0d, got byte=%h v=%b d=%b st=%0d",
                       want.data, want.has_byte, want.done, want.status,
                       out_byte, byte_valid, string_done, decode_status);
          end
        end
      end

      if (in_valid && in_ready) begin
        due = decode_char(char_code, is_last, beat);
        if (due || typed_row)
          decoded_q.insert(decoded_q.size(), typed_row ? typed_beat : beat);
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb NOT OK");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule
